// ----- rtl/cxy_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cxy_pkg: shared types and constants for the CoreXY motor map
// Widths, controller states and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package cxy_pkg;

    localparam int POS_W   = 24;
    localparam int MOTOR_W = POS_W + 2;
    localparam int FEED_W  = 24;
    // difference of motor coords fits MOTOR_W+1 bits, its magnitude MOTOR_W bits;
    // sum of three squares fits 2*MOTOR_W+2
    localparam int DIFF_W  = MOTOR_W + 1;
    localparam int MAG_W   = MOTOR_W;
    localparam int SQ_W    = 2 * MAG_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = FEED_W + ROOT_W;
    localparam logic [FEED_W-1:0] FEED_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQRT,
        ST_NEXT,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;      // latch the request, form differences
        logic [1:0] sq_sel;    // axis to square and accumulate
        logic       sq_en;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       swap;      // save cartesian length, start on motor length
        logic       mul_en;
        logic       div_init;
        logic       div_step;
        logic       finish;    // form result, update stored motor position
    } cmd_t;

    typedef struct packed {
        logic step_last;       // iteration counter at its final step
        logic second;          // working on the motor length
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/corexy_motor_map_feed_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// corexy_motor_map_feed_scale: CoreXY motor mapping with feed scaling
// Maps a Cartesian target to belt motors and scales the feed by the ratio of
// motor to Cartesian move length.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | target, current position, feed, rapid (tuser)
//  m_axis    | out       | motor A/B/Z, feed, saturation flag (tuser)
//  apb       | in/out    | geometry_double at address 0
//
// A request keeps the input closed until the sequencer is idle again: two
// passes of squaring the three axes and a 27-step square root with a swap state
// between them, then one multiply, a 51-step restoring divide and a finish
// state, which registers the result for m_axis. Reset (aresetn low,
// synchronous) clears the stored motor position and geometry_double. A stalled
// m_axis holds the sequencer in its finish state and the input stays closed.
// ----------------------------------------------------------------------------
module corexy_motor_map_feed_scale (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // target_x, target_y, target_z, current_x, current_y, current_z, feed_in
    input  wire logic [167:0] s_tdata,
    // rapid
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // motor_a, motor_b, motor_z, feed_out (zero padded to 104 bits)
    output logic [103:0]      m_tdata,
    // feed_saturated
    output logic              m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int OW = 2 * cxy_pkg::MOTOR_W + cxy_pkg::POS_W + cxy_pkg::FEED_W;

    logic geom_reg;
    logic out_valid_reg;
    logic [OW:0] out_reg;
    logic busy, start, out_free;
    cxy_pkg::cmd_t cmd;
    cxy_pkg::sts_t sts;
    logic [OW:0] res;

    // register file: one bit at address zero
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, geom_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            geom_reg <= pwdata[0];
        end
    end

    // accept a request only while the sequencer idles
    assign s_tready = !busy;
    assign start    = s_tvalid && !busy;
    // output register free now or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    cxy_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    cxy_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .geometry_double (geom_reg),
        .req             ({s_tuser, s_tdata}),
        .sts             (sts),
        .res             (res)
    );

    // hold the finished result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg[OW-1:0]};
    assign m_tuser  = out_reg[OW];

endmodule
`default_nettype wire

// ----- rtl/cxy_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cxy_ctrl: sequencer for the CoreXY motor map
// Steps the datapath through squares, two square roots, multiply and divide.
// ----------------------------------------------------------------------------
module cxy_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic          out_free,
    input  wire cxy_pkg::sts_t sts,
    output cxy_pkg::cmd_t      cmd,
    output logic               busy
);

    cxy_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cxy_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            cxy_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    cmd.load = 1'b1;
                    state_next = cxy_pkg::ST_SQ0;
                end
            end
            cxy_pkg::ST_SQ0: begin
                cmd.sq_en = 1'b1;
                cmd.sq_sel = 2'd0;
                state_next = cxy_pkg::ST_SQ1;
            end
            cxy_pkg::ST_SQ1: begin
                cmd.sq_en = 1'b1;
                cmd.sq_sel = 2'd1;
                state_next = cxy_pkg::ST_SQ2;
            end
            cxy_pkg::ST_SQ2: begin
                cmd.sq_en = 1'b1;
                cmd.sq_sel = 2'd2;
                cmd.sqrt_init = 1'b1;
                state_next = cxy_pkg::ST_SQRT;
            end
            cxy_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.step_last) begin
                    state_next = sts.second ? cxy_pkg::ST_MUL : cxy_pkg::ST_NEXT;
                end
            end
            cxy_pkg::ST_NEXT: begin
                cmd.swap = 1'b1;
                state_next = cxy_pkg::ST_SQ0;
            end
            cxy_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = cxy_pkg::ST_DIV;
                cmd.div_init = 1'b1;
            end
            cxy_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.step_last) begin
                    state_next = cxy_pkg::ST_DONE;
                end
            end
            cxy_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = cxy_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cxy_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/cxy_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cxy_dp: datapath for the CoreXY motor map
// Motor mapping, square sums, bit-pair square root, feed multiply, restoring divider, feed saturation.
// ----------------------------------------------------------------------------
module cxy_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cxy_pkg::cmd_t                 cmd,
    input  wire logic                          geometry_double,
    input  wire logic [6*cxy_pkg::POS_W+cxy_pkg::FEED_W:0] req,
    output cxy_pkg::sts_t                      sts,
    output logic [2*cxy_pkg::MOTOR_W+cxy_pkg::POS_W+cxy_pkg::FEED_W:0] res
);

    localparam int PW = cxy_pkg::POS_W;
    localparam int MW = cxy_pkg::MOTOR_W;
    localparam int DW = cxy_pkg::DIFF_W;
    localparam int SW = cxy_pkg::SQ_W;
    localparam int RW = cxy_pkg::ROOT_W;
    localparam int FW = cxy_pkg::FEED_W;
    localparam int PRW = cxy_pkg::PROD_W;
    localparam int CW = cxy_pkg::CNT_W;

    logic signed [MW-1:0] ma_reg, mb_reg, last_a_reg, last_b_reg;
    logic signed [PW-1:0] mz_reg, last_z_reg;
    logic [FW-1:0] feed_reg;
    logic rapid_reg, second_reg;
    logic signed [DW-1:0] d0_reg, d1_reg, d2_reg;
    logic [SW-1:0] n_reg;
    logic [RW-1:0] root_reg, clen_reg;
    logic [SW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [PRW-1:0] quo_reg;
    logic [RW:0] drem_reg;

    logic signed [PW-1:0] tx, ty, tz, cx, cy, cz;
    logic signed [MW-1:0] gx, ma_c, mb_c;
    logic signed [DW-1:0] dsel;
    logic signed [DW-1:0] dneg;
    logic [DW-2:0] mag;
    logic [SW-1:0] sq;
    logic [SW-1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [SW-1:0] trial_w;
    logic [RW:0] dshift;
    logic sat;
    logic [FW-1:0] fout;

    assign tx = req[PW-1:0];
    assign ty = req[2*PW-1:PW];
    assign tz = req[3*PW-1:2*PW];
    assign cx = req[4*PW-1:3*PW];
    assign cy = req[5*PW-1:4*PW];
    assign cz = req[6*PW-1:5*PW];

    assign gx   = geometry_double ? (MW'(tx) <<< 1) : MW'(tx);
    assign ma_c = gx + MW'(ty);
    assign mb_c = gx - MW'(ty);

    always_comb begin
        case (cmd.sq_sel)
            2'd0:    dsel = d0_reg;
            2'd1:    dsel = d1_reg;
            default: dsel = d2_reg;
        endcase
    end
    assign dneg = -dsel;
    assign mag  = dsel[DW-1] ? dneg[DW-2:0] : dsel[DW-2:0];
    assign sq   = SW'(mag) * SW'(mag);

    // one result bit per step, two radicand bits brought down
    assign rem_sh  = {rem_reg[SW-3:0], n_reg[SW-1:SW-2]};
    assign trial   = {root_reg, 2'b01};
    assign trial_w = SW'(trial);

    assign dshift = {drem_reg[RW-1:0], quo_reg[PRW-1]};

    assign sts.step_last = (cnt_reg == '0);
    assign sts.second    = second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_a_reg <= '0;
            last_b_reg <= '0;
            last_z_reg <= '0;
            second_reg <= 1'b0;
        end else begin
            if (cmd.load) second_reg <= 1'b0;
            if (cmd.swap) second_reg <= 1'b1;
            if (cmd.finish) begin
                last_a_reg <= ma_reg;
                last_b_reg <= mb_reg;
                last_z_reg <= mz_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ma_reg    <= ma_c;
            mb_reg    <= mb_c;
            mz_reg    <= tz;
            feed_reg  <= req[6*PW+FW-1:6*PW];
            rapid_reg <= req[6*PW+FW];
            d0_reg    <= DW'(tx) - DW'(cx);
            d1_reg    <= DW'(ty) - DW'(cy);
            d2_reg    <= DW'(tz) - DW'(cz);
            n_reg     <= '0;
        end
        if (cmd.swap) begin
            clen_reg <= root_reg;
            d0_reg   <= DW'(ma_reg) - DW'(last_a_reg);
            d1_reg   <= DW'(mb_reg) - DW'(last_b_reg);
            d2_reg   <= DW'(mz_reg) - DW'(last_z_reg);
            n_reg    <= '0;
        end
        if (cmd.sq_en) begin
            n_reg <= (cmd.sq_sel == 2'd0) ? sq : n_reg + sq;
        end
        if (cmd.sqrt_init) begin
            root_reg <= '0;
            rem_reg  <= '0;
            cnt_reg  <= CW'(RW - 1);
        end
        if (cmd.sqrt_step) begin
            n_reg <= {n_reg[SW-3:0], 2'b00};
            cnt_reg <= cnt_reg - 1'b1;
            if (rem_sh >= trial_w) begin
                rem_reg  <= rem_sh - trial_w;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (cmd.mul_en) begin
            quo_reg  <= PRW'(feed_reg) * PRW'(root_reg);
        end
        if (cmd.div_init) begin
            drem_reg <= '0;
            cnt_reg  <= CW'(PRW - 1);
        end
        if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (dshift >= {1'b0, clen_reg}) begin
                drem_reg <= dshift - {1'b0, clen_reg};
                quo_reg  <= {quo_reg[PRW-2:0], 1'b1};
            end else begin
                drem_reg <= dshift;
                quo_reg  <= {quo_reg[PRW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        sat  = 1'b0;
        fout = feed_reg;
        if (!rapid_reg && clen_reg != '0) begin
            if (quo_reg[PRW-1:FW] != '0) begin
                sat  = 1'b1;
                fout = cxy_pkg::FEED_MAX;
            end else begin
                fout = quo_reg[FW-1:0];
            end
        end
    end

    assign res = {sat, fout, mz_reg, mb_reg, ma_reg};

endmodule
`default_nettype wire
